// ===== design/dhcts_pkg.sv =====
// Shared types, codes and constants of the DHCP client timeout step unit.
package dhcts_pkg;

    // Default retry round settings
    localparam int MAX_RETRIES_DEF     = 3;
    localparam int RETRY_DELAY_SEC_DEF = 20;

    localparam int MS_PER_SEC     = 1000;
    localparam int LONG_WAIT_SEC  = 10;
    localparam int SHORT_WAIT_SEC = 2;

    // Lease slack divisor 14400 = 2^6 * 225: shift out the power of two, then
    // divide the odd part by a rounded-up reciprocal. With a 26-bit dividend
    // the reciprocal error times the dividend stays below 2^34, so the
    // quotient is exact without correction.
    localparam int LEASE_SLACK_DIV = 14400;
    localparam int SLACK_SHIFT     = 6;
    localparam int SLACK_ODD       = LEASE_SLACK_DIV >> SLACK_SHIFT;
    localparam int RECIP_SHIFT     = 34;
    localparam longint unsigned RECIP_MAGIC =
        ((64'd1 << RECIP_SHIFT) + 64'(SLACK_ODD) - 64'd1) / 64'(SLACK_ODD);
    localparam int LEASE_HI_W = 32 - SLACK_SHIFT;
    localparam int MAGIC_W    = 27;
    localparam int PROD_W     = LEASE_HI_W + MAGIC_W;
    localparam int QUOT_W     = PROD_W - RECIP_SHIFT;
    localparam int MS_W       = 42;

    typedef enum logic [3:0] {
        ST_INIT_SELECTING  = 4'd0,
        ST_RENEW_REQUESTED = 4'd1,
        ST_REQUESTING      = 4'd2,
        ST_RENEWING        = 4'd3,
        ST_BOUND           = 4'd4,
        ST_REBINDING       = 4'd5,
        ST_RELEASED        = 4'd6,
        ST_ARP_CHECK       = 4'd7,
        ST_ARP_GW_CHECK    = 4'd8
    } t_cstate;

    localparam logic [2:0] SEND_NONE      = 3'd0;
    localparam logic [2:0] SEND_DISC      = 3'd1;
    localparam logic [2:0] SEND_SEL_REQ   = 3'd2;
    localparam logic [2:0] SEND_RENEW_UC  = 3'd3;
    localparam logic [2:0] SEND_RENEW_BC  = 3'd4;

    localparam logic [1:0] LISTEN_NONE   = 2'd0;
    localparam logic [1:0] LISTEN_RAW    = 2'd1;
    localparam logic [1:0] LISTEN_KERNEL = 2'd2;

    localparam logic [1:0] NOLEASE_NONE       = 2'd0;
    localparam logic [1:0] NOLEASE_BACKGROUND = 2'd1;
    localparam logic [1:0] NOLEASE_ABORT      = 2'd2;

    localparam logic [1:0] ARP_NONE    = 2'd0;
    localparam logic [1:0] ARP_OK      = 2'd1;
    localparam logic [1:0] ARP_GW_FAIL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BACKGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ABORT      = 1'd1;

    typedef struct packed {
        logic background;
        logic abort_en;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  cur_state;
        logic [3:0]  retry_count;
        logic        first_boot;
        logic [31:0] t1_sec;
        logic [31:0] t2_sec;
        logic [31:0] lease_sec;
        logic [39:0] elapsed_ms;
        logic [31:0] random_word;
        logic [31:0] old_xid;
    } t_item;

    typedef struct packed {
        logic [3:0]         next_state;
        logic [3:0]         next_retry_count;
        logic               next_first_boot;
        logic [31:0]        next_t1_sec;
        logic [31:0]        next_t2_sec;
        logic signed [47:0] timeout_ms;
        logic [2:0]         send_kind;
        logic [31:0]        xid;
        logic               deconfig;
        logic [1:0]         listen_change;
        logic [1:0]         no_lease_action;
        logic [1:0]         arp_event;
    } t_result;

    // Precomputed arithmetic handed from the first stage to the decision stage
    typedef struct packed {
        t_item             item;
        logic [31:0]       diff;
        logic [31:0]       new_off;
        logic [MS_W-1:0]   diff_ms;
        logic [MS_W-1:0]   off_ms;
        logic [QUOT_W-1:0] lease_quot;
        logic [31:0]       disc_ms;
    } t_mid;

endpackage

// ===== design/dhcts_if.sv =====
// Valid/ready channel interfaces for snapshot items and step results.
interface dhcts_item_if;
    import dhcts_pkg::*;

    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dhcts_result_if;
    import dhcts_pkg::*;

    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/dhcts_arith.sv =====
// Input register and arithmetic stage: intervals, halved offsets, ms products, lease slack.
module dhcts_arith #(
    parameter int MAX_RETRIES     = dhcts_pkg::MAX_RETRIES_DEF,
    parameter int RETRY_DELAY_SEC = dhcts_pkg::RETRY_DELAY_SEC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dhcts_item_if.sink        i_item,
    output logic              o_mid_valid,
    output dhcts_pkg::t_mid   o_mid,
    input  logic              i_mid_ready
);
    import dhcts_pkg::*;

    localparam int UNIT_SEC =
        ((RETRY_DELAY_SEC - RETRY_DELAY_SEC / MAX_RETRIES) / MAX_RETRIES) + 1;
    localparam int UNIT_MS = UNIT_SEC * MS_PER_SEC;

    logic  r_in_valid;
    t_item r_in;
    logic  r_mid_valid;
    t_mid  r_mid;
    t_mid  n_mid;

    logic                  w_mid_adv;
    logic                  w_in_adv;
    logic                  w_use_lease;
    logic [31:0]           w_base;
    logic [31:0]           w_top;
    logic [LEASE_HI_W-1:0] w_lease_hi;
    logic [PROD_W-1:0]     w_prod;

    assign w_mid_adv    = !r_mid_valid || i_mid_ready;
    assign w_in_adv     = !r_in_valid || w_mid_adv;
    assign i_item.ready = w_in_adv;
    assign o_mid_valid  = r_mid_valid;
    assign o_mid        = r_mid;

    always_comb begin
        // Rebinding works on lease - T2, renewing on T2 - T1
        w_use_lease = (r_in.cur_state == ST_REBINDING);
        w_base      = w_use_lease ? r_in.t2_sec : r_in.t1_sec;
        w_top       = w_use_lease ? r_in.lease_sec : r_in.t2_sec;
        w_lease_hi  = r_in.lease_sec[31:SLACK_SHIFT];
        w_prod      = PROD_W'(w_lease_hi) * PROD_W'(RECIP_MAGIC);

        n_mid            = '0;
        n_mid.item       = r_in;
        n_mid.diff       = w_top - w_base;
        n_mid.new_off    = w_base + {1'b0, n_mid.diff[31:1]};
        n_mid.diff_ms    = MS_W'(n_mid.diff) * MS_W'(MS_PER_SEC);
        n_mid.off_ms     = MS_W'(n_mid.new_off) * MS_W'(MS_PER_SEC);
        n_mid.lease_quot = w_prod[PROD_W-1:RECIP_SHIFT];
        n_mid.disc_ms    = 32'(UNIT_MS) * (32'(r_in.retry_count) + 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            if (w_in_adv) begin
                r_in_valid <= i_item.valid;
            end
            if (w_mid_adv) begin
                r_mid_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_item.valid) begin
            r_in <= i_item.payload;
        end
        if (w_mid_adv && r_in_valid) begin
            r_mid <= n_mid;
        end
    end

endmodule

// ===== design/dhcts_decide.sv =====
// Decision stage and result register: next state, counters, wait and actions.
module dhcts_decide #(
    parameter int MAX_RETRIES     = dhcts_pkg::MAX_RETRIES_DEF,
    parameter int RETRY_DELAY_SEC = dhcts_pkg::RETRY_DELAY_SEC_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dhcts_pkg::t_cfg  i_cfg,
    input  logic             i_mid_valid,
    input  dhcts_pkg::t_mid  i_mid,
    output logic             o_mid_ready,
    dhcts_result_if.source   o_result
);
    import dhcts_pkg::*;

    localparam logic [3:0]  RETRY_LIM  = 4'(MAX_RETRIES);
    localparam logic [3:0]  RETRY_LAST = 4'(MAX_RETRIES - 1);
    localparam logic [47:0] ROUND_MS   = 48'(RETRY_DELAY_SEC * MS_PER_SEC);
    localparam logic [47:0] LONG_MS    = 48'(LONG_WAIT_SEC * MS_PER_SEC);
    localparam logic [47:0] SHORT_MS   = 48'(SHORT_WAIT_SEC * MS_PER_SEC);

    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic              w_out_adv;
    logic [QUOT_W-1:0] w_slack;
    logic              w_short;
    logic              w_more;
    logic [47:0]       w_off_wait;

    assign w_out_adv        = !r_out_valid || o_result.ready;
    assign o_mid_ready      = w_out_adv;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_comb begin
        w_slack    = i_mid.lease_quot + QUOT_W'(1);
        w_short    = (i_mid.diff <= 32'(w_slack));
        w_more     = (i_mid.item.retry_count < RETRY_LIM);
        w_off_wait = 48'(i_mid.off_ms) - 48'(i_mid.item.elapsed_ms);

        // Pass the snapshot through unless an arm below changes it
        n_out                  = '0;
        n_out.next_state       = i_mid.item.cur_state;
        n_out.next_retry_count = i_mid.item.retry_count;
        n_out.next_first_boot  = i_mid.item.first_boot;
        n_out.next_t1_sec      = i_mid.item.t1_sec;
        n_out.next_t2_sec      = i_mid.item.t2_sec;
        n_out.timeout_ms       = '1;
        n_out.send_kind        = SEND_NONE;
        n_out.xid              = i_mid.item.old_xid;
        n_out.deconfig         = 1'b0;
        n_out.listen_change    = LISTEN_NONE;
        n_out.no_lease_action  = NOLEASE_NONE;
        n_out.arp_event        = ARP_NONE;

        unique case (i_mid.item.cur_state) inside
            ST_INIT_SELECTING: begin
                if (w_more) begin
                    if (i_mid.item.retry_count == 4'd0) begin
                        n_out.xid = i_mid.item.random_word;
                    end
                    n_out.send_kind        = SEND_DISC;
                    n_out.timeout_ms       = 48'(i_mid.disc_ms);
                    n_out.next_retry_count = i_mid.item.retry_count + 4'd1;
                end else begin
                    if (i_mid.item.first_boot) begin
                        if (i_cfg.background) begin
                            n_out.next_first_boot = 1'b0;
                            n_out.no_lease_action = NOLEASE_BACKGROUND;
                        end else if (i_cfg.abort_en) begin
                            n_out.no_lease_action = NOLEASE_ABORT;
                        end
                    end
                    n_out.next_retry_count = 4'd0;
                    n_out.timeout_ms       = ROUND_MS;
                end
            end
            ST_RENEW_REQUESTED, ST_REQUESTING: begin
                if (w_more) begin
                    n_out.send_kind = (i_mid.item.cur_state == ST_RENEW_REQUESTED) ?
                                      SEND_RENEW_UC : SEND_SEL_REQ;
                    n_out.timeout_ms = (i_mid.item.retry_count == RETRY_LAST) ?
                                       LONG_MS : SHORT_MS;
                    n_out.next_retry_count = i_mid.item.retry_count + 4'd1;
                end else begin
                    // Round exhausted: drop back to discovery
                    n_out.deconfig         = (i_mid.item.cur_state == ST_RENEW_REQUESTED);
                    n_out.next_state       = ST_INIT_SELECTING;
                    n_out.timeout_ms       = '0;
                    n_out.next_retry_count = 4'd0;
                    n_out.listen_change    = LISTEN_RAW;
                end
            end
            ST_RENEWING, ST_BOUND: begin
                if (i_mid.item.cur_state == ST_BOUND) begin
                    n_out.next_state    = ST_RENEWING;
                    n_out.listen_change = LISTEN_KERNEL;
                end
                if (w_short) begin
                    n_out.next_state = ST_REBINDING;
                    n_out.timeout_ms = 48'(i_mid.diff_ms);
                end else begin
                    n_out.send_kind   = SEND_RENEW_UC;
                    n_out.next_t1_sec = i_mid.new_off;
                    n_out.timeout_ms  = w_off_wait;
                end
            end
            ST_REBINDING: begin
                if (w_short) begin
                    // Lease ran out
                    n_out.next_state       = ST_INIT_SELECTING;
                    n_out.deconfig         = 1'b1;
                    n_out.timeout_ms       = '0;
                    n_out.next_retry_count = 4'd0;
                    n_out.listen_change    = LISTEN_RAW;
                end else begin
                    n_out.send_kind   = SEND_RENEW_BC;
                    n_out.next_t2_sec = i_mid.new_off;
                    n_out.timeout_ms  = w_off_wait;
                end
            end
            ST_ARP_CHECK: begin
                n_out.arp_event = ARP_OK;
            end
            ST_ARP_GW_CHECK: begin
                n_out.arp_event = ARP_GW_FAIL;
            end
            default: begin
                // Released and unknown codes park in released
                n_out.next_state = ST_RELEASED;
                n_out.timeout_ms = '1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && i_mid_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/dhcp_client_timeout_step_unit.sv =====
// Top level of the DHCP client timeout step unit: config registers and the two stages.
//
//  channel    | dir | handshake     | payload
//  -----------+-----+---------------+------------------------------------------
//  i_item     | in  | valid/ready   | client snapshot at a timeout expiry
//  o_result   | out | valid/ready   | next snapshot, wait in ms and actions
//  i_cfg_*    | in  | write enable  | background / abort on failed first round
//
//  One transaction per cycle sustained while o_result is ready; each result passes
//  through the input register, the arithmetic register and the result register.
//  The lease slack reciprocal multiply and the ms products sit in the middle stage.
//  A stall on o_result holds the result register; earlier stages keep filling empty
//  slots, and i_item.ready drops in the same cycle once all three stages are full.
//  Synchronous active-low reset empties the stages and clears both config bits.
module dhcp_client_timeout_step_unit #(
    parameter int MAX_RETRIES     = dhcts_pkg::MAX_RETRIES_DEF,
    parameter int RETRY_DELAY_SEC = dhcts_pkg::RETRY_DELAY_SEC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dhcts_item_if.sink                         i_item,
    dhcts_result_if.source                     o_result,
    input  logic                               i_cfg_we,
    input  logic [dhcts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dhcts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dhcts_pkg::*;

    t_cfg r_cfg;
    logic w_mid_valid;
    t_mid w_mid;
    logic w_mid_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_BACKGROUND: r_cfg.background <= i_cfg_data[0];
                CFG_IDX_ABORT:      r_cfg.abort_en   <= i_cfg_data[0];
            endcase
        end
    end

    dhcts_arith #(
        .MAX_RETRIES     (MAX_RETRIES),
        .RETRY_DELAY_SEC (RETRY_DELAY_SEC)
    ) u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_mid_valid (w_mid_valid),
        .o_mid       (w_mid),
        .i_mid_ready (w_mid_ready)
    );

    dhcts_decide #(
        .MAX_RETRIES     (MAX_RETRIES),
        .RETRY_DELAY_SEC (RETRY_DELAY_SEC)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_valid (w_mid_valid),
        .i_mid       (w_mid),
        .o_mid_ready (w_mid_ready),
        .o_result    (o_result)
    );

endmodule

// ===== tb/sv/dhcp_client_timeout_step_unit_tb.sv =====
// Self-checking testbench of the DHCP client timeout step unit: directed table, then random snapshots.
module dhcp_client_timeout_step_unit_tb;
    import dhcts_pkg::*;

    localparam int SETTLE_CYC  = 8;
    localparam int HOLD_CYC    = 60;
    localparam int PHASE_ITEMS = 160;
    localparam int CYCLE_LIMIT = 300000;
    // Config per random phase, bit i belongs to phase i
    localparam bit [3:0] PH_BG = 4'b0101;
    localparam bit [3:0] PH_AB = 4'b0110;

    typedef struct {
        t_item   snap;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dhcts_item_if   item_ch ();
    dhcts_result_if res_ch ();

    dhcp_client_timeout_step_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_result     pending_steps[$];
    bit          bg_en = 1'b0;
    bit          ab_en = 1'b0;
    bit          steady = 1'b0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned fault_cnt = 0;
    int unsigned cyc_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Next client snapshot and actions for one timeout expiry
    function automatic t_result next_step(t_item it, bit bg, bit ab);
        t_result     r;
        logic [31:0] slack;
        logic [31:0] gap;
        int unsigned unit_s;
        longint      wait_ms;
        r.next_state       = it.cur_state;
        r.next_retry_count = it.retry_count;
        r.next_first_boot  = it.first_boot;
        r.next_t1_sec      = it.t1_sec;
        r.next_t2_sec      = it.t2_sec;
        r.timeout_ms       = -48'sd1;
        r.send_kind        = SEND_NONE;
        r.xid              = it.old_xid;
        r.deconfig         = 1'b0;
        r.listen_change    = LISTEN_NONE;
        r.no_lease_action  = NOLEASE_NONE;
        r.arp_event        = ARP_NONE;
        unit_s = (RETRY_DELAY_SEC_DEF - RETRY_DELAY_SEC_DEF / MAX_RETRIES_DEF)
                 / MAX_RETRIES_DEF + 1;
        slack = it.lease_sec / LEASE_SLACK_DIV + 1;
        case (it.cur_state)
            ST_INIT_SELECTING: begin
                if (it.retry_count < MAX_RETRIES_DEF) begin
                    if (it.retry_count == 0)
                        r.xid = it.random_word;
                    r.send_kind = SEND_DISC;
                    wait_ms = longint'(unit_s) * (longint'(it.retry_count) + 1) * MS_PER_SEC;
                    r.timeout_ms = wait_ms[47:0];
                    r.next_retry_count = it.retry_count + 4'd1;
                end else begin
                    if (it.first_boot) begin
                        if (bg) begin
                            r.next_first_boot = 1'b0;
                            r.no_lease_action = NOLEASE_BACKGROUND;
                        end else if (ab) begin
                            r.no_lease_action = NOLEASE_ABORT;
                        end
                    end
                    r.next_retry_count = 4'd0;
                    r.timeout_ms = 48'(RETRY_DELAY_SEC_DEF * MS_PER_SEC);
                end
            end
            ST_RENEW_REQUESTED, ST_REQUESTING: begin
                if (it.retry_count < MAX_RETRIES_DEF) begin
                    r.send_kind = (it.cur_state == ST_RENEW_REQUESTED) ?
                                  SEND_RENEW_UC : SEND_SEL_REQ;
                    r.timeout_ms = (it.retry_count == MAX_RETRIES_DEF - 1) ?
                                   48'(LONG_WAIT_SEC * MS_PER_SEC) :
                                   48'(SHORT_WAIT_SEC * MS_PER_SEC);
                    r.next_retry_count = it.retry_count + 4'd1;
                end else begin
                    r.deconfig = (it.cur_state == ST_RENEW_REQUESTED);
                    r.next_state = ST_INIT_SELECTING;
                    r.timeout_ms = 48'sd0;
                    r.next_retry_count = 4'd0;
                    r.listen_change = LISTEN_RAW;
                end
            end
            ST_RENEWING, ST_BOUND: begin
                if (it.cur_state == ST_BOUND) begin
                    r.next_state = ST_RENEWING;
                    r.listen_change = LISTEN_KERNEL;
                end
                gap = it.t2_sec - it.t1_sec;
                if (gap <= slack) begin
                    r.next_state = ST_REBINDING;
                    wait_ms = longint'(gap) * MS_PER_SEC;
                end else begin
                    r.send_kind = SEND_RENEW_UC;
                    r.next_t1_sec = (gap >> 1) + it.t1_sec;
                    wait_ms = longint'(r.next_t1_sec) * MS_PER_SEC - longint'(it.elapsed_ms);
                end
                r.timeout_ms = wait_ms[47:0];
            end
            ST_REBINDING: begin
                gap = it.lease_sec - it.t2_sec;
                if (gap <= slack) begin
                    r.next_state = ST_INIT_SELECTING;
                    r.deconfig = 1'b1;
                    r.timeout_ms = 48'sd0;
                    r.next_retry_count = 4'd0;
                    r.listen_change = LISTEN_RAW;
                end else begin
                    r.send_kind = SEND_RENEW_BC;
                    r.next_t2_sec = (gap >> 1) + it.t2_sec;
                    wait_ms = longint'(r.next_t2_sec) * MS_PER_SEC - longint'(it.elapsed_ms);
                    r.timeout_ms = wait_ms[47:0];
                end
            end
            ST_ARP_CHECK:    r.arp_event = ARP_OK;
            ST_ARP_GW_CHECK: r.arp_event = ARP_GW_FAIL;
            default:         r.next_state = ST_RELEASED;
        endcase
        return r;
    endfunction

    function automatic t_item mk_item(logic [3:0] st, logic [3:0] rc, logic fb,
                                      logic [31:0] t1, logic [31:0] t2, logic [31:0] ls,
                                      logic [39:0] el, logic [31:0] rw, logic [31:0] ox);
        t_item it;
        it.cur_state   = st;
        it.retry_count = rc;
        it.first_boot  = fb;
        it.t1_sec      = t1;
        it.t2_sec      = t2;
        it.lease_sec   = ls;
        it.elapsed_ms  = el;
        it.random_word = rw;
        it.old_xid     = ox;
        return it;
    endfunction

    function automatic t_result mk_res(logic [3:0] st, logic [3:0] rc, logic fb,
                                       logic [31:0] t1, logic [31:0] t2,
                                       logic signed [47:0] tmo, logic [2:0] snd,
                                       logic [31:0] xd, logic dc, logic [1:0] ls,
                                       logic [1:0] nl, logic [1:0] ae);
        t_result r;
        r.next_state       = st;
        r.next_retry_count = rc;
        r.next_first_boot  = fb;
        r.next_t1_sec      = t1;
        r.next_t2_sec      = t2;
        r.timeout_ms       = tmo;
        r.send_kind        = snd;
        r.xid              = xd;
        r.deconfig         = dc;
        r.listen_change    = ls;
        r.no_lease_action  = nl;
        r.arp_event        = ae;
        return r;
    endfunction

    // Interval below an offset: near the slack threshold, exact, wild, or within range
    function automatic logic [31:0] rand_span(logic [31:0] room, logic [31:0] slack);
        case ($urandom_range(4))
            0:       return 32'($urandom_range(slack + 2));
            1:       return slack;
            2:       return 32'($urandom);
            default: return 32'(64'($urandom) % (64'(room) + 64'd1));
        endcase
    endfunction

    function automatic t_item rand_snapshot();
        t_item       it;
        int unsigned pick;
        logic [31:0] slack;
        logic [31:0] off;
        logic [63:0] raw;
        pick = $urandom_range(99);
        if (pick < 18)      it.cur_state = ST_INIT_SELECTING;
        else if (pick < 30) it.cur_state = ST_RENEW_REQUESTED;
        else if (pick < 42) it.cur_state = ST_REQUESTING;
        else if (pick < 58) it.cur_state = ST_RENEWING;
        else if (pick < 70) it.cur_state = ST_BOUND;
        else if (pick < 86) it.cur_state = ST_REBINDING;
        else if (pick < 90) it.cur_state = ST_RELEASED;
        else if (pick < 93) it.cur_state = ST_ARP_CHECK;
        else if (pick < 96) it.cur_state = ST_ARP_GW_CHECK;
        else                it.cur_state = 4'($urandom_range(9, 15));
        it.retry_count = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) :
                                                    4'($urandom_range(3));
        it.first_boot = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       it.lease_sec = $urandom_range(400);
            1:       it.lease_sec = $urandom_range(2000000);
            2:       it.lease_sec = $urandom;
            default: it.lease_sec = 32'hFFFF_FFFF - $urandom_range(100);
        endcase
        slack = it.lease_sec / LEASE_SLACK_DIV + 1;
        it.t2_sec = it.lease_sec - rand_span(it.lease_sec, slack);
        it.t1_sec = it.t2_sec - rand_span(it.t2_sec, slack);
        // Sometimes place the elapsed time near the offset the step will move
        off = (it.cur_state == ST_REBINDING) ? it.t2_sec : it.t1_sec;
        raw = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       it.elapsed_ms = 40'(64'(off) * 1000 - $urandom_range(5000));
            1:       it.elapsed_ms = raw[39:0];
            2:       it.elapsed_ms = 40'($urandom_range(100000));
            default: it.elapsed_ms = 40'hFF_FFFF_FFFF;
        endcase
        it.random_word = $urandom;
        it.old_xid     = $urandom;
        return it;
    endfunction

    task automatic offer(t_item snap, t_result want);
        int unsigned gap_n;
        if (!steady && $urandom_range(99) < 37) begin
            gap_n = ($urandom_range(9) == 0) ? $urandom_range(4, 10) : 1;
            item_ch.valid <= 1'b0;
            repeat (gap_n) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= snap;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        pending_steps.push_back(want);
    endtask

    // Hold the input until every expected result is back, then let the pipe settle
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_cfg(bit bg, bit ab);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_BACKGROUND;
        i_cfg_data <= bg;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_ABORT;
        i_cfg_data <= ab;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bg_en = bg;
        ab_en = ab;
    endtask

    task automatic check_field(string fname, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", fname, want_v, got_v);
            fault_cnt++;
        end
    endtask

    // Receiver: check each result transaction, then pick ready for the next cycle
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = res_ch.payload;
            if (pending_steps.size() == 0) begin
                $error("result transaction with nothing expected");
                fault_cnt++;
            end else begin
                want = pending_steps.pop_front();
                check_field("next_state", 64'(want.next_state), 64'(got.next_state));
                check_field("next_retry_count", 64'(want.next_retry_count),
                            64'(got.next_retry_count));
                check_field("next_first_boot", 64'(want.next_first_boot),
                            64'(got.next_first_boot));
                check_field("next_t1_sec", 64'(want.next_t1_sec), 64'(got.next_t1_sec));
                check_field("next_t2_sec", 64'(want.next_t2_sec), 64'(got.next_t2_sec));
                check_field("timeout_ms", 64'(want.timeout_ms), 64'(got.timeout_ms));
                check_field("send_kind", 64'(want.send_kind), 64'(got.send_kind));
                check_field("xid", 64'(want.xid), 64'(got.xid));
                check_field("deconfig", 64'(want.deconfig), 64'(got.deconfig));
                check_field("listen_change", 64'(want.listen_change),
                            64'(got.listen_change));
                check_field("no_lease_action", 64'(want.no_lease_action),
                            64'(got.no_lease_action));
                check_field("arp_event", 64'(want.arp_event), 64'(got.arp_event));
            end
        end
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYC - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_tab[$];
        t_item    snap;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        res_ch.ready    = 1'b0;

        // Discover: round start, last retry, exhausted round, bogus retry count
        dir_tab.push_back('{mk_item(ST_INIT_SELECTING, 4'd0, 1'b1, 32'd0, 32'd0, 32'd0, 40'd0,
                                    32'hFFFF_FFFF, 32'h1234_5678), 1'b1,
                            mk_res(ST_INIT_SELECTING, 4'd1, 1'b1, 32'd0, 32'd0, 48'sd5000,
                                   SEND_DISC, 32'hFFFF_FFFF, 1'b0, LISTEN_NONE,
                                   NOLEASE_NONE, ARP_NONE)});
        dir_tab.push_back('{mk_item(ST_INIT_SELECTING, 4'd2, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF),
                            1'b0, '0});
        dir_tab.push_back('{mk_item(ST_INIT_SELECTING, 4'd3, 1'b1, 32'd5, 32'd6, 32'd7, 40'd100,
                                    32'hAAAA_AAAA, 32'h5555_5555), 1'b1,
                            mk_res(ST_INIT_SELECTING, 4'd0, 1'b1, 32'd5, 32'd6, 48'sd20000,
                                   SEND_NONE, 32'h5555_5555, 1'b0, LISTEN_NONE,
                                   NOLEASE_NONE, ARP_NONE)});
        dir_tab.push_back('{mk_item(ST_INIT_SELECTING, 4'd15, 1'b0, 32'd1, 32'd2, 32'd3, 40'd0,
                                    32'd77, 32'd88), 1'b0, '0});
        // Request retries and giving up on them
        dir_tab.push_back('{mk_item(ST_RENEW_REQUESTED, 4'd0, 1'b0, 32'd10, 32'd20, 32'd30,
                                    40'd0, 32'd1, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEW_REQUESTED, 4'd2, 1'b0, 32'd10, 32'd20, 32'd30,
                                    40'd0, 32'd1, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEW_REQUESTED, 4'd3, 1'b1, 32'd1, 32'd2, 32'd3, 40'd0,
                                    32'd9, 32'hDEAD_BEEF), 1'b1,
                            mk_res(ST_INIT_SELECTING, 4'd0, 1'b1, 32'd1, 32'd2, 48'sd0,
                                   SEND_NONE, 32'hDEAD_BEEF, 1'b1, LISTEN_RAW,
                                   NOLEASE_NONE, ARP_NONE)});
        dir_tab.push_back('{mk_item(ST_REQUESTING, 4'd1, 1'b1, 32'd0, 32'd0, 32'd0, 40'd0,
                                    32'd3, 32'd4), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_REQUESTING, 4'd3, 1'b0, 32'd0, 32'd0, 32'd0, 40'd0,
                                    32'd3, 32'd4), 1'b0, '0});
        // Renew: bound step, at the slack, wrapped intervals, extremes, negative wait
        dir_tab.push_back('{mk_item(ST_BOUND, 4'd0, 1'b0, 32'd100, 32'd200, 32'd300, 40'd0,
                                    32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEWING, 4'd0, 1'b0, 32'd500, 32'd500, 32'd1000,
                                    40'd0, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEWING, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'd0,
                                    32'hFFFF_FFFF, 40'd0, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEWING, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_BOUND, 4'd0, 1'b0, 32'd0, 32'd4, 32'd4,
                                    40'hFF_FFFF_FFFF, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEWING, 4'd1, 1'b0, 32'd10, 32'd13, 32'd28800,
                                    40'd9000, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_RENEWING, 4'd1, 1'b0, 32'd10, 32'd14, 32'd28800,
                                    40'd9000, 32'd5, 32'd6), 1'b0, '0});
        // Rebind: lease over, at the slack, wide interval, wrapped interval
        dir_tab.push_back('{mk_item(ST_REBINDING, 4'd2, 1'b0, 32'd50, 32'd100, 32'd101,
                                    40'd0, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_REBINDING, 4'd0, 1'b0, 32'd0, 32'd28797, 32'd28800,
                                    40'd0, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_REBINDING, 4'd0, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF,
                                    40'd0, 32'd5, 32'd6), 1'b0, '0});
        dir_tab.push_back('{mk_item(ST_REBINDING, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFF0, 32'd5,
                                    40'd12345, 32'd5, 32'd6), 1'b0, '0});
        // Released, the two ARP states and undefined state codes
        dir_tab.push_back('{mk_item(ST_RELEASED, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF),
                            1'b1,
                            mk_res(ST_RELEASED, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   -48'sd1, SEND_NONE, 32'hFFFF_FFFF, 1'b0, LISTEN_NONE,
                                   NOLEASE_NONE, ARP_NONE)});
        dir_tab.push_back('{mk_item(ST_ARP_CHECK, 4'd5, 1'b0, 32'd10, 32'd20, 32'd30, 40'd123,
                                    32'd7, 32'd8), 1'b1,
                            mk_res(ST_ARP_CHECK, 4'd5, 1'b0, 32'd10, 32'd20, -48'sd1,
                                   SEND_NONE, 32'd8, 1'b0, LISTEN_NONE, NOLEASE_NONE,
                                   ARP_OK)});
        dir_tab.push_back('{mk_item(ST_ARP_GW_CHECK, 4'd1, 1'b1, 32'd10, 32'd20, 32'd30,
                                    40'd123, 32'd7, 32'd8), 1'b1,
                            mk_res(ST_ARP_GW_CHECK, 4'd1, 1'b1, 32'd10, 32'd20, -48'sd1,
                                   SEND_NONE, 32'd8, 1'b0, LISTEN_NONE, NOLEASE_NONE,
                                   ARP_GW_FAIL)});
        dir_tab.push_back('{mk_item(4'd9, 4'd0, 1'b0, 32'd1, 32'd2, 32'd3, 40'd4, 32'd5, 32'd6),
                            1'b0, '0});
        dir_tab.push_back('{mk_item(4'd15, 4'd7, 1'b0, 32'd1, 32'd2, 32'd3, 40'd4, 32'd5,
                                    32'd6), 1'b1,
                            mk_res(ST_RELEASED, 4'd7, 1'b0, 32'd1, 32'd2, -48'sd1, SEND_NONE,
                                   32'd6, 1'b0, LISTEN_NONE, NOLEASE_NONE, ARP_NONE)});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            offer(dir_tab[k].snap, dir_tab[k].typed ? dir_tab[k].want :
                                   next_step(dir_tab[k].snap, bg_en, ab_en));
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            set_cfg(PH_BG[ph], PH_AB[ph]);
            steady = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 40)
                    hold_asks++;
                if (ph == 1 && n == 80)
                    drain_results();
                if (ph == 2 && n == 100)
                    steady = 1'b0;
                snap = rand_snapshot();
                offer(snap, next_step(snap, bg_en, ab_en));
            end
            drain_results();
        end

        if (fault_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
